FILE: rtl/core/debounced_edge_sequence_recorder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the edge sequence recorder
// Shared concurrent checks, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DEBOUNCED_EDGE_SEQUENCE_RECORDER_ASSERT_SVH
`define DEBOUNCED_EDGE_SEQUENCE_RECORDER_ASSERT_SVH

// same-cycle implication
`define DESR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define DESR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/desr_pkg.sv
// ---------------------------------------------------------------------------
// desr_pkg
// Types and constants shared by the edge sequence recorder modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package desr_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned DEB_W   = 15;
  localparam int unsigned REC_W   = 8;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned CODES_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 15'd50;
  localparam logic [TICK_W-1:0] WINDOW_RST   = 16'd50000;
  localparam logic [REC_W-1:0]  RECORD_RST   = 8'd0;
  localparam logic [TICK_W-1:0] TICK_MAX     = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_START_REC = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic opcode;
    logic edge_line;
    logic edge_rising;
  } item_t;

  typedef struct packed {
    logic [REC_W-1:0]   record_number;
    logic [CNT_W-1:0]   event_count;
    logic [CODES_W-1:0] packed_codes;
    logic               timed_out;
  } result_t;

endpackage

FILE: rtl/core/desr_in_reg.sv
// ---------------------------------------------------------------------------
// desr_in_reg
// Input register: captures one word per cycle and holds it until processed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module desr_in_reg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [desr_pkg::IN_DATA_W-1:0]       in_tdata,   // edge_line, edge_rising
  input  logic                                 in_tuser,   // opcode
  input  logic                                 advance,
  output logic                                 item_valid,
  output desr_pkg::item_t                      item
);

  logic            valid_r;
  desr_pkg::item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.opcode      <= in_tuser;
      item_r.edge_line   <= in_tdata[0];
      item_r.edge_rising <= in_tdata[1];
    end
  end

endmodule

FILE: rtl/core/desr_core.sv
// ---------------------------------------------------------------------------
// desr_core
// Session state, debounce check, code packing and record generation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module desr_core #(
  parameter int unsigned MAX_EVENTS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [desr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [desr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 go,
  input  desr_pkg::item_t                      item,
  output logic                                 res_valid,
  output desr_pkg::result_t                    result
);

  localparam logic [desr_pkg::CNT_W-1:0] MAX_CNT = desr_pkg::CNT_W'(MAX_EVENTS);

  logic [desr_pkg::DEB_W-1:0]    debounce_r;
  logic [desr_pkg::TICK_W-1:0]   window_r;
  logic [desr_pkg::REC_W-1:0]    record_r,  record_nxt;
  logic                          active_r,  active_nxt;
  logic [desr_pkg::TICK_W-1:0]   elapsed_r, elapsed_nxt;
  logic [desr_pkg::TICK_W-1:0]   last_r [2];
  logic [desr_pkg::TICK_W-1:0]   last_nxt [2];
  logic [1:0]                    seen_r,    seen_nxt;
  logic [desr_pkg::CODES_W-1:0]  packed_r,  packed_nxt;
  logic [desr_pkg::CNT_W-1:0]    count_r,   count_nxt;

  logic [desr_pkg::TICK_W-1:0]   el_base;
  logic [1:0]                    seen_base;
  logic [desr_pkg::CODES_W-1:0]  packed_base;
  logic [desr_pkg::CNT_W-1:0]    count_base;
  logic [desr_pkg::TICK_W-1:0]   gap;
  logic                          accept;

  always_comb begin
    active_nxt  = active_r;
    elapsed_nxt = elapsed_r;
    last_nxt    = last_r;
    seen_nxt    = seen_r;
    packed_nxt  = packed_r;
    count_nxt   = count_r;
    record_nxt  = record_r;
    res_valid   = 1'b0;
    result      = '0;

    if (cfg_we && (desr_pkg::cfg_reg_t'(cfg_index) == desr_pkg::REG_START_REC)) begin
      record_nxt = cfg_data[desr_pkg::REC_W-1:0];
    end

    el_base     = active_r ? elapsed_r : '0;
    seen_base   = active_r ? seen_r    : 2'b00;
    packed_base = active_r ? packed_r  : '0;
    count_base  = active_r ? count_r   : '0;
    gap         = el_base - last_r[item.edge_line];
    accept      = !seen_base[item.edge_line] || (gap >= {1'b0, debounce_r});

    if (go) begin
      if (item.opcode == desr_pkg::OP_TICK) begin
        if (active_r) begin
          elapsed_nxt = (elapsed_r != desr_pkg::TICK_MAX) ? elapsed_r + 1'b1 : elapsed_r;
          if (elapsed_nxt >= window_r) begin
            record_nxt           = record_r + 1'b1;
            res_valid            = 1'b1;
            result.record_number = record_nxt;
            result.event_count   = count_r;
            result.packed_codes  = packed_r;
            result.timed_out     = 1'b1;
            active_nxt           = 1'b0;
            count_nxt            = '0;
          end
        end
      end else begin
        active_nxt  = 1'b1;
        elapsed_nxt = el_base;
        seen_nxt    = seen_base;
        packed_nxt  = packed_base;
        count_nxt   = count_base;
        if (accept) begin
          packed_nxt = {packed_base[desr_pkg::CODES_W-3:0], item.edge_rising, item.edge_line};
          count_nxt  = count_base + 1'b1;
          last_nxt[item.edge_line] = el_base;
          seen_nxt[item.edge_line] = 1'b1;
          if (count_nxt >= MAX_CNT) begin
            record_nxt           = record_r + 1'b1;
            res_valid            = 1'b1;
            result.record_number = record_nxt;
            result.event_count   = count_nxt;
            result.packed_codes  = packed_nxt;
            result.timed_out     = 1'b0;
            active_nxt           = 1'b0;
            count_nxt            = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= desr_pkg::DEBOUNCE_RST;
      window_r   <= desr_pkg::WINDOW_RST;
      record_r   <= desr_pkg::RECORD_RST;
      active_r   <= 1'b0;
      elapsed_r  <= '0;
      seen_r     <= 2'b00;
      count_r    <= '0;
    end else begin
      active_r  <= active_nxt;
      elapsed_r <= elapsed_nxt;
      seen_r    <= seen_nxt;
      count_r   <= count_nxt;
      record_r  <= record_nxt;
      if (cfg_we) begin
        unique case (desr_pkg::cfg_reg_t'(cfg_index))
          desr_pkg::REG_DEBOUNCE:  debounce_r <= cfg_data[desr_pkg::DEB_W-1:0];
          desr_pkg::REG_WINDOW:    window_r   <= cfg_data[desr_pkg::TICK_W-1:0];
          desr_pkg::REG_START_REC: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    packed_r  <= packed_nxt;
    last_r[0] <= last_nxt[0];
    last_r[1] <= last_nxt[1];
  end

endmodule

FILE: rtl/core/desr_out_reg.sv
// ---------------------------------------------------------------------------
// desr_out_reg
// Result register: holds one record word until the sink takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module desr_out_reg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 go,
  input  logic                                 res_valid,
  input  desr_pkg::result_t                    result,
  output logic                                 advance,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [desr_pkg::OUT_DATA_W-1:0]      out_tdata,  // record_number, event_count,
                                                           // packed_codes
  output logic                                 out_tuser   // timed_out
);

  logic              valid_r;
  desr_pkg::result_t res_r;

  assign advance    = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {5'b0, res_r.packed_codes, res_r.event_count, res_r.record_number};
  assign out_tuser  = res_r.timed_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= go && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) begin
      res_r <= result;
    end
  end

endmodule

FILE: rtl/core/debounced_edge_sequence_recorder.sv
// ---------------------------------------------------------------------------
// debounced_edge_sequence_recorder
// Top level: input register, session logic and record output register.
// ---------------------------------------------------------------------------
// Takes one word per clock (a tick, or an edge on one of two lines) and emits
// one record when a session closes, either after MAX_EVENTS debounced edges
// or when elapsed ticks reach the window. Each word passes an input register
// and then the session logic, which writes the record register; input and
// output stall only when the record register is full and not being taken.
// Configuration writes are always ready; writing start_record_count loads the
// record counter at once. Write configuration only while the block is idle.
`timescale 1ns / 1ps

module debounced_edge_sequence_recorder #(
  parameter int unsigned MAX_EVENTS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [desr_pkg::IN_DATA_W-1:0]       in_tdata,   // [0] edge_line, [1] edge_rising
  input  logic                                 in_tuser,   // [0] opcode
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [desr_pkg::OUT_DATA_W-1:0]      out_tdata,  // [7:0] record_number,
                                                           // [10:8] event_count,
                                                           // [18:11] packed_codes
  output logic                                 out_tuser,  // [0] timed_out
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [desr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [desr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [desr_pkg::CNT_W-1:0] MAX_CNT = desr_pkg::CNT_W'(MAX_EVENTS);

  logic                       item_valid;
  desr_pkg::item_t            item;
  logic                       advance;
  logic                       go;
  logic                       res_valid;
  desr_pkg::result_t          result;
  logic [desr_pkg::CNT_W-1:0] out_count;

  assign cfg_ready = 1'b1;
  assign go        = item_valid && advance;
  assign out_count = out_tdata[10:8];

  desr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  desr_core #(
    .MAX_EVENTS (MAX_EVENTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (go),
    .item      (item),
    .res_valid (res_valid),
    .result    (result)
  );

  desr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .res_valid  (res_valid),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`include "debounced_edge_sequence_recorder_assert.svh"

  `DESR_ASSERT_NOW(a_count_range, out_tvalid, (out_count != 3'd0) && (out_count <= MAX_CNT))
  `DESR_ASSERT_NOW(a_full_close, out_tvalid && !out_tuser, out_count == MAX_CNT)
  `DESR_ASSERT_NOW(a_stall_blocks, item_valid && out_tvalid && !out_tready, !in_tready && !go)
  `DESR_ASSERT_NEXT(a_result_lands, go && res_valid, out_tvalid)

endmodule

FILE: dv/desr_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge sequence recorder checker
// Watches the configuration, input and record channels of the recorder. It
// keeps its own copy of the session state, works out the record each accepted
// word closes, and compares every record taken from the block, field by field,
// with the oldest one still due.
// ----------------------------------------------------------------------------
module desr_record_checker
  import desr_pkg::*;
#(
  parameter int unsigned MAX_EVENTS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] edge_line, [1] edge_rising
  input  logic                  in_tuser,   // [0] opcode
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] record_number, [10:8] event_count,
                                            // [18:11] packed_codes
  input  logic                  out_tuser,  // [0] timed_out
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    n_waiting,
  output int                    n_failed
);

  logic [DEB_W-1:0]   debounce_q;
  logic [TICK_W-1:0]  window_q;
  logic [REC_W-1:0]   record_ctr;
  logic               session_on;
  logic [TICK_W-1:0]  elapsed;
  logic [TICK_W-1:0]  last_accept [2];
  logic [1:0]         line_seen;
  logic [CODES_W-1:0] codes;
  logic [CNT_W-1:0]   accepted;
  result_t            records_due [$];
  int                 fails = 0;

  assign n_failed = fails;

  task automatic seal_record(input logic by_timeout);
    result_t rec;
    record_ctr = record_ctr + 1'b1;
    rec.record_number = record_ctr;
    rec.event_count   = accepted;
    rec.packed_codes  = codes;
    rec.timed_out     = by_timeout;
    records_due.push_back(rec);
    session_on = 1'b0;
    accepted   = '0;
  endtask

  task automatic take_word(input logic op, input logic line, input logic rising);
    logic [TICK_W-1:0] since;
    if (op == OP_TICK) begin
      if (session_on) begin
        if (elapsed != TICK_MAX) elapsed = elapsed + 1'b1;
        if (elapsed >= window_q) seal_record(1'b1);
      end
    end else begin
      if (!session_on) begin
        session_on = 1'b1;
        elapsed    = '0;
        line_seen  = '0;
        codes      = '0;
        accepted   = '0;
      end
      since = elapsed - last_accept[line];
      if (!line_seen[line] || since >= TICK_W'(debounce_q)) begin
        codes = {codes[CODES_W-3:0], rising, line};
        accepted = accepted + 1'b1;
        last_accept[line] = elapsed;
        line_seen[line] = 1'b1;
        if (accepted >= MAX_EVENTS) seal_record(1'b0);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      debounce_q     = DEBOUNCE_RST;
      window_q       = WINDOW_RST;
      record_ctr     = RECORD_RST;
      session_on     = 1'b0;
      elapsed        = '0;
      last_accept[0] = '0;
      last_accept[1] = '0;
      line_seen      = '0;
      codes          = '0;
      accepted       = '0;
      records_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE:  debounce_q = cfg_data[DEB_W-1:0];
          REG_WINDOW:    window_q   = cfg_data[TICK_W-1:0];
          REG_START_REC: record_ctr = cfg_data[REC_W-1:0];
          default: ;
        endcase
      end
      // check the record before predicting, so a stray one is never matched
      if (out_tvalid && out_tready) begin
        if (records_due.size() == 0) begin
          $error("record with none due: tdata %h, tuser %b", out_tdata, out_tuser);
          fails++;
        end else begin
          want = records_due.pop_front();
          check_field("record_number", 32'(want.record_number),
                      32'(out_tdata[REC_W-1:0]));
          check_field("event_count", 32'(want.event_count),
                      32'(out_tdata[REC_W+CNT_W-1:REC_W]));
          check_field("packed_codes", 32'(want.packed_codes),
                      32'(out_tdata[REC_W+CNT_W+CODES_W-1:REC_W+CNT_W]));
          check_field("timed_out", 32'(want.timed_out), 32'(out_tuser));
        end
      end
      if (in_tvalid && in_tready) take_word(in_tuser, in_tdata[0], in_tdata[1]);
    end
    n_waiting <= records_due.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge sequence recorder testbench
// Drives ticks and edges into the recorder with random gaps and random
// back-pressure on the record side: a short hand-made sequence first, then
// random phases under changing debounce, window and record-count settings,
// and finally one session under a debounce of 20000 that times out.
// The checker beside the block predicts and compares every record.
// ----------------------------------------------------------------------------
module tb;
  import desr_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned RANDOM_PHASES   = 24;
  localparam int unsigned WORDS_PER_PHASE = 72;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [0] edge_line, [1] edge_rising
  logic                  in_tuser = 1'b0; // [0] opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [7:0] record_number, [10:8] event_count,
                                          // [18:11] packed_codes
  logic                  out_tuser;       // [0] timed_out
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    n_waiting;
  int                    n_failed;
  int                    in_gap_max = 12;
  int                    out_stall_max = 12;
  logic [DEB_W-1:0]      debounce_now = DEBOUNCE_RST;

  debounced_edge_sequence_recorder #(.MAX_EVENTS(4)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  desr_record_checker #(.MAX_EVENTS(4)) rec_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .n_waiting(n_waiting), .n_failed(n_failed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic push_word(input logic op, input logic line, input logic rising);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({rising, line});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_word(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // drop valid, drain the records due, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // hold valid between back-to-back writes; the caller drops it after the last
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DEBOUNCE) debounce_now = data[DEB_W-1:0];
  endtask

  initial begin : sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    int   sent;
    int   n;
    int   spacing;
    logic quiet;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: idle tick, first edges on both lines, debounced repeats
    push_word(OP_TICK, 1'b1, 1'b1);
    push_word(OP_EDGE, 1'b0, 1'b0);
    push_word(OP_EDGE, 1'b1, 1'b1);
    push_word(OP_EDGE, 1'b0, 1'b1);
    push_word(OP_EDGE, 1'b1, 1'b0);
    // change debounce while the session is open
    settle();
    cfg_write(REG_DEBOUNCE, 16'd0);
    cfg_valid <= 1'b0;
    push_word(OP_EDGE, 1'b0, 1'b1);
    push_word(OP_EDGE, 1'b1, 1'b0);

    // zero window, record count loaded at the top so it wraps
    settle();
    cfg_write(REG_WINDOW, 16'd0);
    cfg_write(REG_START_REC, 16'd255);
    cfg_valid <= 1'b0;
    push_word(OP_EDGE, 1'b1, 1'b1);
    push_word(OP_TICK, 1'b0, 1'b0);

    settle();
    cfg_write(REG_WINDOW, 16'd3);
    cfg_write(REG_DEBOUNCE, 16'd2);
    cfg_valid <= 1'b0;
    push_word(OP_EDGE, 1'b0, 1'b0);
    push_word(OP_TICK, 1'b0, 1'b0);
    push_word(OP_EDGE, 1'b0, 1'b1);
    push_word(OP_TICK, 1'b1, 1'b0);
    push_word(OP_EDGE, 1'b0, 1'b1);
    push_word(OP_TICK, 1'b0, 1'b1);

    // unknown index ignored; debounce top bit falls away
    settle();
    cfg_write(REG_UNUSED, 16'hFFFF);
    cfg_write(REG_DEBOUNCE, 16'h8001);
    cfg_write(REG_WINDOW, 16'd2);
    cfg_valid <= 1'b0;
    push_word(OP_EDGE, 1'b1, 1'b0);
    push_word(OP_EDGE, 1'b1, 1'b1);
    push_word(OP_TICK, 1'b0, 1'b0);
    push_word(OP_EDGE, 1'b1, 1'b1);
    push_word(OP_EDGE, 1'b0, 1'b0);
    push_word(OP_EDGE, 1'b0, 1'b1);
    push_word(OP_TICK, 1'b1, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: cfg_write(REG_DEBOUNCE, 16'($urandom_range(0, 4)));
          6, 7:             cfg_write(REG_DEBOUNCE, 16'($urandom_range(5, 40)));
          8:                cfg_write(REG_DEBOUNCE, 16'd20000);
          default:          cfg_write(REG_DEBOUNCE, 16'($urandom));
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: cfg_write(REG_WINDOW, 16'($urandom_range(1, 30)));
          6, 7:             cfg_write(REG_WINDOW, 16'($urandom_range(31, 300)));
          8:                cfg_write(REG_WINDOW, 16'($urandom_range(0, 1)));
          default:          cfg_write(REG_WINDOW, 16'($urandom_range(301, 65535)));
        endcase
      end
      if ($urandom_range(0, 3) == 0) cfg_write(REG_START_REC, 16'($urandom));
      if ($urandom_range(0, 7) == 0) cfg_write(REG_UNUSED, 16'($urandom));
      cfg_valid <= 1'b0;

      quiet = ($urandom_range(0, 3) == 0);
      in_gap_max    = quiet ? 0 : 12;
      out_stall_max = quiet ? 0 : 12;
      spacing = (debounce_now < 30) ? int'(debounce_now) + 2 : 30;
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 4) != 0) begin
          n = $urandom_range(0, spacing);
          push_word(OP_EDGE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          push_ticks(n);
          sent += n + 1;
        end else begin
          push_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end

    // debounce of 20000, no idling: repeats on one line drop, the window closes it
    settle();
    cfg_write(REG_DEBOUNCE, 16'd20000);
    cfg_write(REG_WINDOW, 16'd40);
    cfg_valid <= 1'b0;
    in_gap_max    = 0;
    out_stall_max = 0;
    push_word(OP_EDGE, 1'b0, 1'b0);
    push_ticks(5);
    push_word(OP_EDGE, 1'b0, 1'b1);
    push_word(OP_EDGE, 1'b1, 1'b1);
    push_ticks(40);

    settle();
    if (n_failed == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/desr_pkg.sv
rtl/core/desr_in_reg.sv
rtl/core/desr_core.sv
rtl/core/desr_out_reg.sv
rtl/core/debounced_edge_sequence_recorder.sv
dv/desr_record_checker.sv
dv/tb.sv
